### design/lgeo_pkg.sv
// lgeo_pkg: shared constants, status codes and the divider pipeline word
// for the letterbox geometry block; depends on nothing
package lgeo_pkg;

  // side of the square model input
  localparam int INPUT_SIZE = 640;

  localparam int IN_W   = 16;                          // image dimension width
  localparam int OUT_W  = 13;                          // result field width
  localparam int SIZE_W = $clog2(INPUT_SIZE + 1);      // bits of a scaled side
  localparam int NUM_W  = IN_W + SIZE_W;               // short side times size

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO     = 2'd1;
  localparam logic [1:0] ST_COLLAPSE = 2'd2;

  // word handed from one divider cell to the next
  typedef struct packed {
    logic              valid;
    logic              zero;    // an input dimension was zero
    logic              h_long;  // height is the long side
    logic [NUM_W-1:0]  rem;     // partial remainder
    logic [NUM_W-1:0]  dsh;     // divisor aligned to the current quotient bit
    logic [IN_W-1:0]   den;     // divisor, kept for rounding
    logic [SIZE_W-1:0] quo;     // quotient bits so far
  } div_word_t;

endpackage

### design/letterbox_geometry_unit.sv
// letterbox_geometry_unit: top level of the letterbox geometry block
// uses lgeo_pkg, lgeo_front, lgeo_div_cell and lgeo_back
//
// usage
//   an input word (image_height, image_width) is taken at a rising edge
//   with start high and busy low. busy is high only while rst is held, so
//   a new word may be started in every cycle.
//   each result word appears on scaled_height, scaled_width, the four pad
//   ports and status for exactly one cycle, marked by done. the receiver
//   cannot hold results off; result words leave in input order.
//   a word runs through these registers in order: the front stage, which
//   picks the long side and multiplies the short side by the input size;
//   the row of divider cells, one per quotient bit (SIZE_W of them); the
//   rounding register, which rounds half to even; and the output register,
//   which forms pads and status.
//   throughput is one word per cycle while rst is low: every divider cell
//   holds a different word and hands it on in each cycle.
//   status: ok, zero input dimension, or short side rounded to zero; in the
//   latter two cases all sizes and pads read zero.
//   reset (synchronous) clears every valid bit in the pipeline; words in
//   flight are dropped and done stays low until new words come through.
module letterbox_geometry_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [lgeo_pkg::IN_W-1:0]  image_height,
  input  logic [lgeo_pkg::IN_W-1:0]  image_width,
  output logic                       done,
  output logic [lgeo_pkg::OUT_W-1:0] scaled_height,
  output logic [lgeo_pkg::OUT_W-1:0] scaled_width,
  output logic [lgeo_pkg::OUT_W-1:0] pad_top,
  output logic [lgeo_pkg::OUT_W-1:0] pad_bottom,
  output logic [lgeo_pkg::OUT_W-1:0] pad_left,
  output logic [lgeo_pkg::OUT_W-1:0] pad_right,
  output logic [1:0]                 status
);

  // chain[0] leaves the front stage, chain[k] leaves divider cell k-1
  lgeo_pkg::div_word_t chain [0:lgeo_pkg::SIZE_W];

  logic load;

  // the pipeline never stalls, so only reset holds off new words
  assign busy = rst;
  assign load = start && !busy;

  lgeo_front u_front (
    .clk          (clk),
    .rst          (rst),
    .load         (load),
    .image_height (image_height),
    .image_width  (image_width),
    .word         (chain[0])
  );

  // row of division cells, most significant quotient bit first
  for (genvar k = 0; k < lgeo_pkg::SIZE_W; k++) begin : g_cell
    lgeo_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .word_in  (chain[k]),
      .word_out (chain[k+1])
    );
  end

  lgeo_back u_back (
    .clk           (clk),
    .rst           (rst),
    .word_in       (chain[lgeo_pkg::SIZE_W]),
    .done          (done),
    .scaled_height (scaled_height),
    .scaled_width  (scaled_width),
    .pad_top       (pad_top),
    .pad_bottom    (pad_bottom),
    .pad_left      (pad_left),
    .pad_right     (pad_right),
    .status        (status)
  );

endmodule

### design/lgeo_front.sv
// lgeo_front: picks long and short side, scales the short side by the
// model input size and loads the first divider word; uses lgeo_pkg
module lgeo_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      load,
  input  logic [lgeo_pkg::IN_W-1:0] image_height,
  input  logic [lgeo_pkg::IN_W-1:0] image_width,
  output lgeo_pkg::div_word_t       word
);

  logic                        h_long;
  logic [lgeo_pkg::IN_W-1:0]   side_short;
  logic [lgeo_pkg::IN_W-1:0]   side_long;
  logic [lgeo_pkg::NUM_W-1:0]  num;

  assign h_long     = (image_height >= image_width);
  assign side_short = h_long ? image_width : image_height;
  assign side_long  = h_long ? image_height : image_width;
  assign num        = lgeo_pkg::NUM_W'(side_short)
                    * lgeo_pkg::NUM_W'(lgeo_pkg::INPUT_SIZE);

  always_ff @(posedge clk) begin
    if (rst) begin
      word.valid <= 1'b0;
    end else begin
      word.valid <= load;
    end
    word.zero   <= (image_height == '0) || (image_width == '0);
    word.h_long <= h_long;
    word.rem    <= num;
    word.dsh    <= lgeo_pkg::NUM_W'(side_long) << (lgeo_pkg::SIZE_W - 1);
    word.den    <= side_long;
    word.quo    <= '0;
  end

endmodule

### design/lgeo_div_cell.sv
// lgeo_div_cell: one restoring division step, one quotient bit per cell;
// uses lgeo_pkg
module lgeo_div_cell (
  input  logic                clk,
  input  logic                rst,
  input  lgeo_pkg::div_word_t word_in,
  output lgeo_pkg::div_word_t word_out
);

  logic q_bit;

  assign q_bit = (word_in.rem >= word_in.dsh);

  always_ff @(posedge clk) begin
    if (rst) begin
      word_out.valid <= 1'b0;
    end else begin
      word_out.valid <= word_in.valid;
    end
    word_out.zero   <= word_in.zero;
    word_out.h_long <= word_in.h_long;
    word_out.rem    <= q_bit ? (word_in.rem - word_in.dsh) : word_in.rem;
    word_out.dsh    <= word_in.dsh >> 1;
    word_out.den    <= word_in.den;
    word_out.quo    <= lgeo_pkg::SIZE_W'({word_in.quo, q_bit});
  end

endmodule

### design/lgeo_back.sv
// lgeo_back: rounds the quotient half to even, then forms sizes, pads and
// status in a registered result word; uses lgeo_pkg
module lgeo_back (
  input  logic                       clk,
  input  logic                       rst,
  input  lgeo_pkg::div_word_t        word_in,
  output logic                       done,
  output logic [lgeo_pkg::OUT_W-1:0] scaled_height,
  output logic [lgeo_pkg::OUT_W-1:0] scaled_width,
  output logic [lgeo_pkg::OUT_W-1:0] pad_top,
  output logic [lgeo_pkg::OUT_W-1:0] pad_bottom,
  output logic [lgeo_pkg::OUT_W-1:0] pad_left,
  output logic [lgeo_pkg::OUT_W-1:0] pad_right,
  output logic [1:0]                 status
);

  localparam logic [lgeo_pkg::SIZE_W-1:0] SIZE = lgeo_pkg::SIZE_W'(lgeo_pkg::INPUT_SIZE);

  // rounding stage
  logic [lgeo_pkg::NUM_W:0]    twice;
  logic [lgeo_pkg::NUM_W:0]    den_ext;
  logic                        inc;
  logic                        r_valid;
  logic                        r_zero;
  logic                        r_hlong;
  logic [lgeo_pkg::SIZE_W-1:0] r_side;

  // pad stage
  logic [lgeo_pkg::SIZE_W-1:0] pad_all;
  logic [lgeo_pkg::SIZE_W-1:0] pad_lo;
  logic [lgeo_pkg::SIZE_W-1:0] pad_hi;

  assign twice   = {word_in.rem, 1'b0};
  assign den_ext = (lgeo_pkg::NUM_W + 1)'(word_in.den);
  assign inc     = (twice > den_ext) || ((twice == den_ext) && word_in.quo[0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
    end else begin
      r_valid <= word_in.valid;
    end
    r_zero  <= word_in.zero;
    r_hlong <= word_in.h_long;
    r_side  <= word_in.quo + lgeo_pkg::SIZE_W'(inc);
  end

  assign pad_all = SIZE - r_side;
  assign pad_lo  = pad_all >> 1;
  assign pad_hi  = pad_all - pad_lo;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= r_valid;
    end
    if (r_zero) begin
      status        <= lgeo_pkg::ST_ZERO;
      scaled_height <= '0;
      scaled_width  <= '0;
      pad_top       <= '0;
      pad_bottom    <= '0;
      pad_left      <= '0;
      pad_right     <= '0;
    end else if (r_side == '0) begin
      status        <= lgeo_pkg::ST_COLLAPSE;
      scaled_height <= '0;
      scaled_width  <= '0;
      pad_top       <= '0;
      pad_bottom    <= '0;
      pad_left      <= '0;
      pad_right     <= '0;
    end else if (r_hlong) begin
      status        <= lgeo_pkg::ST_OK;
      scaled_height <= lgeo_pkg::OUT_W'(SIZE);
      scaled_width  <= lgeo_pkg::OUT_W'(r_side);
      pad_top       <= '0;
      pad_bottom    <= '0;
      pad_left      <= lgeo_pkg::OUT_W'(pad_lo);
      pad_right     <= lgeo_pkg::OUT_W'(pad_hi);
    end else begin
      status        <= lgeo_pkg::ST_OK;
      scaled_height <= lgeo_pkg::OUT_W'(r_side);
      scaled_width  <= lgeo_pkg::OUT_W'(SIZE);
      pad_top       <= lgeo_pkg::OUT_W'(pad_lo);
      pad_bottom    <= lgeo_pkg::OUT_W'(pad_hi);
      pad_left      <= '0;
      pad_right     <= '0;
    end
  end

endmodule
